// ===== src/dpbp_pkg.sv =====
// Shared package for the depth pixel back-projection block.
// Holds field widths, register index codes, reset values and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package dpbp_pkg;

  // Default geometry limits
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Field widths
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned FW_W       = 13;
  localparam int unsigned CENTER_W   = 20;
  localparam int unsigned INV_W      = 32;
  localparam int unsigned POINT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 2 * POINT_W + DEPTH_W;

  // Register index codes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH   = 8'd7;

  // Register reset values
  localparam logic [FW_W-1:0]     FRAME_WIDTH_RST = 13'd640;
  localparam logic [FW_W-1:0]     COLUMN_STEP_RST = 13'd1;
  localparam logic [CENTER_W-1:0] CENTER_X_RST    = 20'd81920;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 20'd61440;
  localparam logic [INV_W-1:0]    INV_FOCAL_RST   = 32'd0;
  localparam logic [DEPTH_W-1:0]  MIN_DEPTH_RST   = 16'd600;
  localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST   = 16'd8000;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;   // input side may take a transaction
    logic mod_step;   // one remainder iteration
    logic diff;       // form |coord*256 - center| and its sign
    logic prod;       // magnitude times depth
    logic part;       // partial products with the reciprocal
    logic sum;        // combine partials and round
    logic load;       // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;   // input transaction offered
    logic pass;       // depth and reciprocals allow a point
    logic stride;     // column stride check needed
    logic rem_zero;   // remainder after current step is zero
    logic out_free;   // output register can take a new point
  } status_t;

endpackage

`default_nettype wire

// ===== src/depth_pixel_back_projection_top.sv =====
// Depth pixel back-projection, top level. An accepted pixel goes through the
// states DIFF, PROD, PART, SUM and OUT to output valid, after a bit-serial column
// remainder (one column bit per step) when a column stride of 2 or more is set.
// A pixel dropped by the stride or rejected on depth or reciprocal returns to idle
// with no output. A new pixel is taken only once the last one is done, and a held
// output stalls the block. Async active-low reset clears counters, state, output valid.
`default_nettype none

module depth_pixel_back_projection_top #(
  parameter int unsigned MAX_WIDTH  = dpbp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = dpbp_pkg::MAX_HEIGHT_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [dpbp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [dpbp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [dpbp_pkg::DEPTH_W-1:0]     s_axis_tdata,  // [15:0] depth_mm
  input  wire                             s_axis_tuser,  // [0] frame_start
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [dpbp_pkg::OUT_DATA_W-1:0] m_axis_tdata   // [31:0] point_x, [63:32] point_y,
                                                         // [79:64] point_z
);
  import dpbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  dpbp_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dpbp_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

`default_nettype wire

// ===== src/dpbp_ctrl.sv =====
// Sequencing state machine for depth pixel back-projection.
// Depends on dpbp_pkg (cmd_t, status_t).
`default_nettype none

module dpbp_ctrl #(
  parameter int unsigned MAX_WIDTH = dpbp_pkg::MAX_WIDTH_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire dpbp_pkg::status_t status_i,
  output dpbp_pkg::cmd_t         cmd_o
);
  import dpbp_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W = $clog2(COL_W + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_DIFF = 7'b0000100,
    S_PROD = 7'b0001000,
    S_PART = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign accept = (state_q == S_IDLE) && status_i.in_valid;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (accept && status_i.pass) begin
          if (status_i.stride) begin
            state_d = S_MOD;
            cnt_d   = CNT_W'(COL_W - 1);
          end else begin
            state_d = S_DIFF;
          end
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = status_i.rem_zero ? S_DIFF : S_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_PART;
      end
      S_PART: begin
        cmd_o.part = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        cmd_o.load = status_i.out_free;
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // A pixel that needs no stride check goes straight to the arithmetic
  a_no_stride_to_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_i.pass && !status_i.stride |=> state_q == S_DIFF)
    else $error("pixel without stride check did not start arithmetic");

  // A rejected pixel leaves the block ready for the next one
  a_reject_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !status_i.pass |=> cmd_o.in_ready)
    else $error("rejected pixel did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== src/dpbp_axis.sv =====
// One projection axis: |coord*256 - center| * depth * inv / 2^36, rounded
// half away from zero, signed and saturated. Depends on dpbp_pkg (cmd_t).
`default_nettype none

module dpbp_axis #(
  parameter int unsigned COORD_W = 12
) (
  input  wire                                 clk_i,
  input  wire dpbp_pkg::cmd_t                 cmd_i,
  input  wire [COORD_W-1:0]                   coord_i,
  input  wire [dpbp_pkg::CENTER_W-1:0]        center_i,
  input  wire [dpbp_pkg::DEPTH_W-1:0]         depth_i,
  input  wire [dpbp_pkg::INV_W-1:0]           inv_i,
  output logic signed [dpbp_pkg::POINT_W-1:0] point_o
);
  import dpbp_pkg::*;

  localparam int unsigned SH_W  = COORD_W + 8;
  localparam int unsigned MAG_W = (SH_W > CENTER_W) ? SH_W : CENTER_W;
  localparam int unsigned M_W   = MAG_W + DEPTH_W;
  localparam int unsigned P_W   = M_W + 16;
  localparam int unsigned Q_W   = M_W + 17;
  localparam int unsigned R_W   = Q_W - 20;

  logic [MAG_W-1:0] pix, ctr, mag_d, mag_q;
  logic             neg_d, neg_q;
  logic [M_W-1:0]   m_q;
  logic [P_W-1:0]   a_q, b_q;
  logic [Q_W-1:0]   sum;
  logic [R_W-1:0]   r_q;
  logic [63:0]      r_ext;

  // Signed offset from the principal point, as sign and magnitude
  always_comb begin
    pix   = MAG_W'({coord_i, 8'h00});
    ctr   = MAG_W'(center_i);
    neg_d = pix < ctr;
    mag_d = neg_d ? (ctr - pix) : (pix - ctr);
  end

  // Rounding add over the two partial products
  assign sum = Q_W'(a_q) + Q_W'(b_q[P_W-1:16]) + Q_W'(32'h0008_0000);

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
    end
    if (cmd_i.prod) begin
      m_q <= M_W'(mag_q * depth_i);
    end
    if (cmd_i.part) begin
      a_q <= P_W'(m_q * inv_i[31:16]);
      b_q <= P_W'(m_q * inv_i[15:0]);
    end
    if (cmd_i.sum) begin
      r_q <= sum[Q_W-1:20];
    end
  end

  // Apply sign and saturate to 32 bits
  always_comb begin
    r_ext = 64'(r_q);
    if (neg_q) begin
      point_o = (r_ext >= 64'h8000_0000) ? 32'sh8000_0000 : signed'(32'd0 - r_ext[31:0]);
    end else begin
      point_o = (r_ext > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(r_ext[31:0]);
    end
  end

endmodule

`default_nettype wire

// ===== src/dpbp_dp.sv =====
// Datapath: configuration registers, column/row counters, stride remainder
// unit, two projection axes and the output register.
// Depends on dpbp_pkg and dpbp_axis.
`default_nettype none

module dpbp_dp #(
  parameter int unsigned MAX_WIDTH  = dpbp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = dpbp_pkg::MAX_HEIGHT_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [dpbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [dpbp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire [dpbp_pkg::DEPTH_W-1:0]        s_axis_tdata,   // depth_mm
  input  wire                                s_axis_tuser,   // frame_start
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [dpbp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // point_x, point_y, point_z
  input  wire dpbp_pkg::cmd_t                cmd_i,
  output dpbp_pkg::status_t                  status_o
);
  import dpbp_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);

  // Configuration registers
  logic [FW_W-1:0]     frame_width_q, column_step_q;
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [INV_W-1:0]    inv_x_q, inv_y_q;
  logic [DEPTH_W-1:0]  min_depth_q, max_depth_q;

  // Counters and per-pixel registers
  logic [COL_W-1:0]   col_q, col_d, col_base, u_q, ushift_q;
  logic [ROW_W-1:0]   row_q, row_d, row_base, v_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [WID_W-1:0]   stride_q, rem_q, width_w, u_w, u_inc;
  logic [WID_W:0]     rem_sh, rem_next;
  logic [31:0]        fw_ext, step_ext, width_ext, stride_ext;
  logic               accept, wrap, stride_on;

  // Output register
  logic                      out_valid_q;
  logic [POINT_W-1:0]        out_x_q, out_y_q;
  logic [DEPTH_W-1:0]        out_z_q;
  logic signed [POINT_W-1:0] px, py;

  assign s_axis_tready = cmd_i.in_ready;
  assign accept        = cmd_i.in_ready && s_axis_tvalid;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FRAME_WIDTH_RST;
      column_step_q <= COLUMN_STEP_RST;
      center_x_q    <= CENTER_X_RST;
      center_y_q    <= CENTER_Y_RST;
      inv_x_q       <= INV_FOCAL_RST;
      inv_y_q       <= INV_FOCAL_RST;
      min_depth_q   <= MIN_DEPTH_RST;
      max_depth_q   <= MAX_DEPTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH: frame_width_q <= cfg_data_i[FW_W-1:0];
        REG_COLUMN_STEP: column_step_q <= cfg_data_i[FW_W-1:0];
        REG_CENTER_X:    center_x_q    <= cfg_data_i[CENTER_W-1:0];
        REG_CENTER_Y:    center_y_q    <= cfg_data_i[CENTER_W-1:0];
        REG_INV_FOCAL_X: inv_x_q       <= cfg_data_i[INV_W-1:0];
        REG_INV_FOCAL_Y: inv_y_q       <= cfg_data_i[INV_W-1:0];
        REG_MIN_DEPTH:   min_depth_q   <= cfg_data_i[DEPTH_W-1:0];
        REG_MAX_DEPTH:   max_depth_q   <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective width and stride
  always_comb begin
    fw_ext   = 32'(frame_width_q);
    step_ext = 32'(column_step_q);
    if (fw_ext == 32'd0) begin
      width_ext = 32'd1;
    end else if (fw_ext > MAX_WIDTH) begin
      width_ext = MAX_WIDTH;
    end else begin
      width_ext = fw_ext;
    end
    stride_ext = (step_ext > width_ext) ? width_ext : step_ext;
    stride_on  = (step_ext > 32'd1) && (stride_ext > 32'd1);
    width_w    = width_ext[WID_W-1:0];
  end

  // Pixel coordinates and counter advance
  always_comb begin
    col_base = s_axis_tuser ? '0 : col_q;
    row_base = s_axis_tuser ? '0 : row_q;
    u_w      = (WID_W'(col_base) >= width_w) ? '0 : WID_W'(col_base);
    u_inc    = u_w + 1'b1;
    wrap     = u_inc >= width_w;
    col_d    = wrap ? '0 : u_inc[COL_W-1:0];
    row_d    = row_base;
    if (wrap && (row_base < ROW_W'(MAX_HEIGHT - 1))) begin
      row_d = row_base + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Restoring remainder, one column bit per step
  always_comb begin
    rem_sh   = {rem_q, ushift_q[COL_W-1]};
    rem_next = (rem_sh >= {1'b0, stride_q}) ? (rem_sh - {1'b0, stride_q}) : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      u_q      <= u_w[COL_W-1:0];
      v_q      <= row_base;
      depth_q  <= s_axis_tdata;
      stride_q <= stride_ext[WID_W-1:0];
      ushift_q <= u_w[COL_W-1:0];
      rem_q    <= '0;
    end else if (cmd_i.mod_step) begin
      ushift_q <= ushift_q << 1;
      rem_q    <= rem_next[WID_W-1:0];
    end
  end

  // Status to the controller
  always_comb begin
    status_o.in_valid = s_axis_tvalid;
    status_o.pass     = (inv_x_q != '0) && (inv_y_q != '0) && (s_axis_tdata != '0) &&
                        (s_axis_tdata >= min_depth_q) && (s_axis_tdata <= max_depth_q);
    status_o.stride   = stride_on;
    status_o.rem_zero = rem_next == '0;
    status_o.out_free = !out_valid_q || m_axis_tready;
  end

  // Projection axes
  dpbp_axis #(.COORD_W(COL_W)) u_axis_x (
    .clk_i    (clk_i),
    .cmd_i    (cmd_i),
    .coord_i  (u_q),
    .center_i (center_x_q),
    .depth_i  (depth_q),
    .inv_i    (inv_x_q),
    .point_o  (px)
  );

  dpbp_axis #(.COORD_W(ROW_W)) u_axis_y (
    .clk_i    (clk_i),
    .cmd_i    (cmd_i),
    .coord_i  (v_q),
    .center_i (center_y_q),
    .depth_i  (depth_q),
    .inv_i    (inv_y_q),
    .point_o  (py)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_x_q <= px;
      out_y_q <= py;
      out_z_q <= depth_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_z_q, out_y_q, out_x_q};

`ifndef ASSERT_OFF
  // Never overwrite a point that is still waiting
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten while held");

  // Row counter saturates at the last row
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) <= MAX_HEIGHT - 1)
    else $error("row counter beyond last row");

  // Column counter stays within the largest frame
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MAX_WIDTH)
    else $error("column counter beyond widest row");
`endif

endmodule

`default_nettype wire
